// ----- rtl/core/edpg_pkg.sv -----
// ----------------------------------------------------------------------------
// edpg_pkg
// Types and constants shared by the edge delayed pulse generator.
// ----------------------------------------------------------------------------
package edpg_pkg;

  localparam logic [15:0] WaitTimeout = 16'hFFFF;
  localparam logic [9:0]  SaveCycles  = 10'd1000;
  localparam logic [11:0] MaxSetting  = 12'd3000;
  localparam logic [11:0] MinSetting  = 12'd10;
  localparam logic [11:0] StepSize    = 12'd10;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_DELAY_START = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_WIDTH_START = CfgIdxW'(1);

  typedef enum logic [6:0] {
    PH_START    = 7'b0000001,
    PH_WAIT_HI  = 7'b0000010,
    PH_DELAY_HI = 7'b0000100,
    PH_PULSE_HI = 7'b0001000,
    PH_WAIT_LO  = 7'b0010000,
    PH_DELAY_LO = 7'b0100000,
    PH_PULSE_LO = 7'b1000000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] tick;
    logic [11:0] delay;
    logic [11:0] width;
    logic        key_latch;
    logic [9:0]  save_cnt;
    logic        led;
  } state_t;

  typedef struct packed {
    logic        pulse_out;
    logic        led_out;
    logic        save_strobe;
    logic [11:0] save_delay;
    logic [11:0] save_width;
  } result_t;

endpackage

// ----- rtl/core/edpg_step.sv -----
// ----------------------------------------------------------------------------
// edpg_step
// Next-state and result logic for one tick of the pulse generator.
// ----------------------------------------------------------------------------
module edpg_step
  import edpg_pkg::*;
(
  input  state_t     st_i,
  input  logic       sync_i,
  input  logic [3:0] keys_n_i,
  output state_t     st_o,
  output result_t    res_o
);

  function automatic logic [11:0] step_up(input logic [11:0] v);
    logic [12:0] s;
    s = {1'b0, v} + {1'b0, StepSize};
    if (v >= MaxSetting) begin
      return v;
    end
    if (s > {1'b0, MaxSetting}) begin
      return MaxSetting;
    end
    return s[11:0];
  endfunction

  function automatic logic [11:0] step_down(input logic [11:0] v);
    if (v <= MinSetting) begin
      return v;
    end
    if ((v - MinSetting) < StepSize) begin
      return MinSetting;
    end
    return v - StepSize;
  endfunction

  logic [15:0] tick_inc;
  logic        wait_over;
  logic        pulse;
  logic        strobe;
  logic [11:0] dly;
  logic [11:0] wid;
  logic        latch;
  logic [9:0]  cnt;

  assign tick_inc  = st_i.tick + 16'd1;
  assign wait_over = (tick_inc >= WaitTimeout) || (tick_inc == 16'd0);

  always_comb begin
    st_o   = st_i;
    pulse  = 1'b0;
    strobe = 1'b0;
    dly    = st_i.delay;
    wid    = st_i.width;
    latch  = st_i.key_latch;
    cnt    = st_i.save_cnt;
    unique case (st_i.phase) inside
      PH_WAIT_HI, PH_WAIT_LO: begin
        if (((st_i.phase == PH_WAIT_HI) == sync_i) || wait_over) begin
          st_o.tick  = '0;
          st_o.phase = (st_i.phase == PH_WAIT_HI) ? PH_DELAY_HI : PH_DELAY_LO;
        end else begin
          st_o.tick = tick_inc;
        end
      end
      PH_DELAY_HI, PH_DELAY_LO: begin
        if (tick_inc >= {4'd0, st_i.delay}) begin
          st_o.tick  = '0;
          st_o.phase = (st_i.phase == PH_DELAY_HI) ? PH_PULSE_HI : PH_PULSE_LO;
        end else begin
          st_o.tick = tick_inc;
        end
      end
      PH_PULSE_HI, PH_PULSE_LO: begin
        pulse = 1'b1;
        if (tick_inc >= {4'd0, st_i.width}) begin
          st_o.tick = '0;
          if (st_i.phase == PH_PULSE_HI) begin
            st_o.phase = PH_WAIT_LO;
          end else begin
            st_o.phase = PH_START;
            if (latch && (keys_n_i == 4'hF)) begin
              latch = 1'b0;
              cnt   = SaveCycles;
            end
            if (cnt != 10'd0) begin
              cnt    = cnt - 10'd1;
              strobe = (cnt == 10'd0);
            end
          end
        end else begin
          st_o.tick = tick_inc;
        end
      end
      default: begin
        if (!st_i.key_latch) begin
          if (!keys_n_i[0]) begin
            dly   = step_up(dly);
            latch = 1'b1;
          end
          if (!keys_n_i[1]) begin
            dly   = step_down(dly);
            latch = 1'b1;
          end
          if (!keys_n_i[2]) begin
            wid   = step_up(wid);
            latch = 1'b1;
          end
          if (!keys_n_i[3]) begin
            wid   = step_down(wid);
            latch = 1'b1;
          end
        end
        st_o.led = ~st_i.led;
        if (sync_i || (16'd1 >= WaitTimeout)) begin
          st_o.tick  = '0;
          st_o.phase = PH_DELAY_HI;
        end else begin
          st_o.tick  = 16'd1;
          st_o.phase = PH_WAIT_HI;
        end
      end
    endcase
    st_o.delay     = dly;
    st_o.width     = wid;
    st_o.key_latch = latch;
    st_o.save_cnt  = cnt;
  end

  assign res_o.pulse_out   = pulse;
  assign res_o.led_out     = st_o.led;
  assign res_o.save_strobe = strobe;
  assign res_o.save_delay  = st_o.delay;
  assign res_o.save_width  = st_o.width;

endmodule

// ----- rtl/core/edge_delayed_pulse_generator.sv -----
// ----------------------------------------------------------------------------
// edge_delayed_pulse_generator
// Sync-edge delayed trigger pulse generator with key-adjustable settings.
// ----------------------------------------------------------------------------
// One input beat is one microsecond tick. A beat passes an input register,
// one pass of next-state logic and a result register, and a new beat is
// taken every cycle while input is not stalled. The input register doubles
// as a skid stage: input is stalled only while both registers hold beats
// and the result is not taken. Each sync cycle toggles
// led, applies key steps of 10 (range 10..3000), waits for sync high then sync
// low (each wait up to 65535 ticks), and after each edge waits delay ticks and
// drives the pulse for width ticks. save_strobe fires at the end of the 999th
// sync cycle after the one whose last tick sees the keys released.
// Config writes are always ready and load the working values directly.
// ----------------------------------------------------------------------------
module edge_delayed_pulse_generator
  import edpg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [0] sync_level, [4:1] keys_n, [7:5] zero
  input  logic [7:0]          s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] pulse_out, [1] led_out, [2] save_strobe, [14:3] save_delay,
  // [26:15] save_width, [31:27] zero
  output logic [31:0]         m_axis_tdata_o
);

  function automatic logic [11:0] validate(input logic [15:0] v);
    if ((v == 16'd0) || (v > {4'd0, MaxSetting})) begin
      return MinSetting;
    end
    return v[11:0];
  endfunction

  logic       in_valid_q;
  logic       sync_q;
  logic [3:0] keys_q;
  logic       out_valid_q;
  result_t    res_q;
  result_t    res_d;
  state_t     st_q;
  state_t     st_d;
  state_t     st_step;
  logic       advance;
  logic       cfg_wr;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = 1'b1;
  assign cfg_wr          = cfg_valid_i && cfg_ready_o;

  edpg_step u_step (
    .st_i     (st_q),
    .sync_i   (sync_q),
    .keys_n_i (keys_q),
    .st_o     (st_step),
    .res_o    (res_d)
  );

  always_comb begin
    st_d = st_q;
    if (advance) begin
      st_d = st_step;
    end
    if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_DELAY_START: st_d.delay = validate(cfg_data_i);
        CFG_WIDTH_START: st_d.width = validate(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q.phase     <= PH_START;
      st_q.tick      <= '0;
      st_q.delay     <= MinSetting;
      st_q.width     <= MinSetting;
      st_q.key_latch <= 1'b0;
      st_q.save_cnt  <= '0;
      st_q.led       <= 1'b0;
    end else begin
      st_q <= st_d;
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      sync_q <= s_axis_tdata_i[0];
      keys_q <= s_axis_tdata_i[4:1];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, res_q.save_width, res_q.save_delay,
                            res_q.save_strobe, res_q.led_out, res_q.pulse_out};

  a_delay_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.delay != 12'd0 && st_q.width != 12'd0)
    else $error("working delay or width is zero");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input register dropped a stalled beat");

  a_strobe_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.save_strobe |=> st_q.phase == PH_START)
    else $error("save strobe outside cycle end");

  a_pulse_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.pulse_out |-> st_q.phase == PH_PULSE_HI || st_q.phase == PH_PULSE_LO)
    else $error("pulse driven outside pulse phase");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the edge delayed pulse generator.
// ----------------------------------------------------------------------------
// Feeds tick beats (sync level plus keys) and compares every result beat with
// a cycle-true predictor kept in a small scoreboard class. Sync patterns mostly
// follow the predicted phase so that whole sync cycles run; the rest is noise.
// Covers key steps and saturation, start values that get replaced, a sync
// input stuck low, and back-pressure that fills the block. Idle rates on both
// stream sides change between phases.
// ----------------------------------------------------------------------------
module tb_top
  import edpg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 3000;

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = CfgIdxW'(3);

  localparam logic [3:0] KeysNone      = 4'b1111;
  localparam logic [3:0] KeysAll       = 4'b0000;
  localparam logic [3:0] KeysUpBoth    = 4'b1010;
  localparam logic [3:0] KeysDownBoth  = 4'b0101;
  localparam logic [3:0] KeysDelayDown = 4'b1101;

  typedef enum {KEYS_RANDOM, KEYS_ONCE} key_mode_e;
  typedef enum {SYNC_LOOSE, SYNC_STRICT, SYNC_STUCK_LOW} sync_mode_e;

  class pulse_scoreboard;
    phase_e      phase;
    logic [15:0] tick;
    logic [11:0] delay_val;
    logic [11:0] width_val;
    bit          latch;
    logic [9:0]  save_cnt;
    bit          led;
    result_t     expected_q[$];
    int          errors;

    function new();
      phase     = PH_START;
      tick      = '0;
      delay_val = clean_start(16'd10);
      width_val = clean_start(16'd10);
      latch     = 1'b0;
      save_cnt  = '0;
      led       = 1'b0;
      errors    = 0;
    endfunction

    function logic [11:0] clean_start(logic [15:0] v);
      if (v == 16'd0 || v > 16'(MaxSetting)) return MinSetting;
      return v[11:0];
    endfunction

    function logic [11:0] raise(logic [11:0] v);
      if (v < MaxSetting) begin
        v = v + StepSize;
        if (v > MaxSetting) v = MaxSetting;
      end
      return v;
    endfunction

    function logic [11:0] lower(logic [11:0] v);
      if (v > MinSetting) v = (v - MinSetting < StepSize) ? MinSetting : v - StepSize;
      return v;
    endfunction

    // one sync check, 1 when the wait is over
    function bit sync_check(bit matched);
      tick = tick + 16'd1;
      if (matched || tick >= WaitTimeout || tick == 16'd0) begin
        tick = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void load_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
      if (idx == CFG_DELAY_START) delay_val = clean_start(val);
      else if (idx == CFG_WIDTH_START) width_val = clean_start(val);
    endfunction

    function void note_input(logic [7:0] beat);
      bit         sync;
      logic [3:0] keys;
      result_t    r;
      sync = beat[0];
      keys = beat[4:1];
      r    = '0;
      case (phase)
        PH_WAIT_HI: if (sync_check(sync)) phase = PH_DELAY_HI;
        PH_WAIT_LO: if (sync_check(!sync)) phase = PH_DELAY_LO;
        PH_DELAY_HI, PH_DELAY_LO: begin
          tick = tick + 16'd1;
          if (tick >= 16'(delay_val)) begin
            tick  = '0;
            phase = (phase == PH_DELAY_HI) ? PH_PULSE_HI : PH_PULSE_LO;
          end
        end
        PH_PULSE_HI, PH_PULSE_LO: begin
          r.pulse_out = 1'b1;
          tick = tick + 16'd1;
          if (tick >= 16'(width_val)) begin
            tick = '0;
            if (phase == PH_PULSE_HI) begin
              phase = PH_WAIT_LO;
            end else begin
              phase = PH_START;
              if (latch && keys == KeysNone) begin
                latch    = 1'b0;
                save_cnt = SaveCycles;
              end
              if (save_cnt != '0) begin
                save_cnt = save_cnt - 10'd1;
                if (save_cnt == '0) r.save_strobe = 1'b1;
              end
            end
          end
        end
        default: begin
          if (!latch) begin
            if (!keys[0]) begin delay_val = raise(delay_val); latch = 1'b1; end
            if (!keys[1]) begin delay_val = lower(delay_val); latch = 1'b1; end
            if (!keys[2]) begin width_val = raise(width_val); latch = 1'b1; end
            if (!keys[3]) begin width_val = lower(width_val); latch = 1'b1; end
          end
          led   = !led;
          tick  = '0;
          phase = sync_check(sync) ? PH_DELAY_HI : PH_WAIT_HI;
        end
      endcase
      r.led_out    = led;
      r.save_delay = delay_val;
      r.save_width = width_val;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [31:0] beat);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat %h with none expected, expected -, actual %h",
                 $time, beat, beat);
        return;
      end
      want = expected_q.pop_front();
      compare_field("pulse_out", 12'(want.pulse_out), 12'(beat[0]));
      compare_field("led_out", 12'(want.led_out), 12'(beat[1]));
      compare_field("save_strobe", 12'(want.save_strobe), 12'(beat[2]));
      compare_field("save_delay", want.save_delay, beat[14:3]);
      compare_field("save_width", want.save_width, beat[26:15]);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [31:0]         m_axis_tdata_o;

  pulse_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;

  edge_delayed_pulse_generator dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.load_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_settings(logic [15:0] dly, logic [15:0] wid);
    drain();
    write_reg(CFG_DELAY_START, dly);
    write_reg(CFG_WIDTH_START, wid);
  endtask

  function automatic logic [15:0] pick_setting();
    case ($urandom_range(19))
      0: return 16'h0000;
      1: return 16'(MaxSetting) + 16'd1;
      2: return 16'hFFFF;
      3: return 16'h8000;
      default: return 16'($urandom_range(24, 1));
    endcase
  endfunction

  task automatic send_ticks(int count, key_mode_e kmode, logic [3:0] press,
                            sync_mode_e smode);
    logic       sync;
    logic [3:0] keys;
    logic [7:0] beat;
    bit         pressed;
    pressed = 1'b0;
    for (int i = 0; i < count; i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
      case (smode)
        SYNC_STUCK_LOW: sync = 1'b0;
        SYNC_STRICT: sync = !(sb.phase inside {PH_WAIT_LO, PH_DELAY_LO, PH_PULSE_LO});
        default: begin
          sync = 1'($urandom_range(1));
          if ($urandom_range(99) < 70) begin
            if (sb.phase inside {PH_START, PH_WAIT_HI}) sync = 1'b1;
            if (sb.phase == PH_WAIT_LO) sync = 1'b0;
          end
        end
      endcase
      if (kmode == KEYS_ONCE) begin
        keys = KeysNone;
        if (!pressed && sb.phase == PH_START && !sb.latch) begin
          keys    = press;
          pressed = 1'b1;
        end
      end else begin
        keys = ($urandom_range(99) < 60) ? KeysNone : 4'($urandom_range(15));
      end
      beat = {3'b000, keys, sync};
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= beat;
      do @(posedge clk_i); while (!s_axis_tready_o);
      sb.note_input(beat);
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic run_random(int count);
    load_settings(pick_setting(), pick_setting());
    send_ticks(count, KEYS_RANDOM, KeysNone, SYNC_LOOSE);
  endtask

  // result side: random stalls plus one long hold on request
  initial begin : result_sink
    int hold;
    hold = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      if (hold_req > 0) begin
        hold     = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : main_seq
    sb              = new();
    send_idle_pct   = 31;
    recv_idle_pct   = 85;
    hold_req        = 0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values, all keys at once
    send_ticks(25, KEYS_ONCE, KeysAll, SYNC_STRICT);
    run_random(200);
    drain();
    write_reg(CfgIdxUnused, 16'hFFFF);
    run_random(200);

    send_idle_pct = 85;
    recv_idle_pct = 31;
    run_random(200);
    run_random(200);
    // small start values below the floor
    load_settings(16'd1, 16'd1);
    send_ticks(200, KEYS_ONCE, KeysDelayDown, SYNC_STRICT);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // saturation at the top
    load_settings(16'd2995, 16'(MaxSetting));
    send_ticks(100, KEYS_ONCE, KeysUpBoth, SYNC_STRICT);
    // saturation at the floor
    load_settings(16'd15, 16'(MinSetting));
    send_ticks(100, KEYS_ONCE, KeysDownBoth, SYNC_STRICT);
    run_random(200);
    // long result-side hold while beats keep coming
    load_settings(pick_setting(), pick_setting());
    hold_req = 400;
    send_ticks(200, KEYS_RANDOM, KeysNone, SYNC_LOOSE);
    // sync stuck low
    load_settings(16'd1, 16'd1);
    send_ticks(200, KEYS_RANDOM, KeysNone, SYNC_STUCK_LOW);

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/edpg_pkg.sv
rtl/core/edpg_step.sv
rtl/core/edge_delayed_pulse_generator.sv
tb/tb_top.sv
